// ===== design/mtf_pkg.sv =====
// Shared constants, types and helpers for the max-tracking queue.
`default_nettype none

package mtf_pkg;

    // Default queue depth
    localparam int DEPTH_DEFAULT = 256;

    // Width of one stored value and of the signed result words
    localparam int VALUE_W = 31;
    localparam int WORD_W  = 32;
    localparam int OCC_W   = 9;
    localparam int STAT_W  = 2;

    // Operation codes carried in the input tuser
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Result word that stands for "no value"
    localparam logic [WORD_W-1:0] NONE_WORD = {WORD_W{1'b1}};

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic               push;
        logic               pop;
        logic [VALUE_W-1:0] push_value;
    } cell_ctrl_t;

    // Larger of two unsigned values
    function automatic logic [VALUE_W-1:0] max_val(
        input logic [VALUE_W-1:0] a,
        input logic [VALUE_W-1:0] b
    );
        max_val = (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== design/max_tracking_fifo.sv =====
// Top level: first-in first-out queue built as a row of cells that tracks its maximum.
// Each input transfer's result is held on the output register from the next cycle.
// Throughput: one item per cycle while the output register is free or being drained;
// the whole cell row updates together, since each cell keeps the maximum of itself and
// every younger entry, so a pop needs no rescan. Reset: occupancy clears to zero and the
// output goes invalid; cell contents stay undefined until written and take no clearing pass.
`default_nettype none

module max_tracking_fifo #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [31:0]                          s_axis_tdata,  // [30:0] value
    input  wire                                  s_axis_tuser,  // [0] kind
    // Result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [79:0]                          m_axis_tdata,  // [31:0] popped_value,
                                                                 // [63:32] current_max,
                                                                 // [72:64] occupancy
    output logic [mtf_pkg::STAT_W-1:0]           m_axis_tuser   // [1:0] status
);
    import mtf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [WORD_W-1:0]  popped_reg;
    logic [WORD_W-1:0]  popped_next;
    logic [WORD_W-1:0]  max_reg;
    logic [WORD_W-1:0]  max_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;

    logic               accept;
    logic               empty;
    logic               full;
    logic [VALUE_W-1:0] in_value;
    cell_ctrl_t         ctrl;

    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [VALUE_W-1:0] cell_smax  [DEPTH];

    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_COUNT);

    // Take a new item whenever the output register is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Broadcast the operation to the cell row; refused steps leave it untouched
    assign ctrl.push       = accept && (s_axis_tuser == KIND_PUSH) && !full;
    assign ctrl.pop        = accept && (s_axis_tuser == KIND_POP) && !empty;
    assign ctrl.push_value = in_value;

    // Row of cells, cell zero at the head, each fed by its younger neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_W-1:0] nb_value;
        logic [VALUE_W-1:0] nb_smax;

        if (g == DEPTH-1)
        begin : g_last
            assign nb_value = '0;
            assign nb_smax  = '0;
        end
        else
        begin : g_mid
            assign nb_value = cell_value[g+1];
            assign nb_smax  = cell_smax[g+1];
        end

        mtf_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .count    (count_reg),
            .nb_value (nb_value),
            .nb_smax  (nb_smax),
            .value    (cell_value[g]),
            .smax     (cell_smax[g])
        );
    end

    // Form the result of the accepted item
    always_comb
    begin
        count_next  = count_reg;
        popped_next = NONE_WORD;
        max_next    = NONE_WORD;
        status_next = STAT_OK;
        if (s_axis_tuser == KIND_PUSH)
        begin
            if (full)
            begin
                status_next = STAT_FULL;
                max_next    = {1'b0, cell_smax[0]};
            end
            else
            begin
                count_next = count_reg + ONE_COUNT;
                max_next   = empty ? {1'b0, in_value}
                                   : {1'b0, max_val(cell_smax[0], in_value)};
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                count_next  = count_reg - ONE_COUNT;
                popped_next = {1'b0, cell_value[0]};
                max_next    = (count_reg == ONE_COUNT) ? NONE_WORD : {1'b0, cell_smax[1]};
            end
        end
        occ_next = OCC_W'(count_next);
    end

    // Hold the output until the transfer completes
    assign out_valid_next = accept || (out_valid_reg && !m_axis_tready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            max_reg    <= max_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, occ_reg, max_reg, popped_reg};
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

// ===== design/mtf_cell.sv =====
// One queue cell: holds an entry and the maximum of itself and all younger entries.
`default_nettype none

module mtf_cell #(
    parameter int DEPTH = 256,
    parameter int INDEX = 0
) (
    input  wire                                   clk,
    input  mtf_pkg::cell_ctrl_t                   ctrl,
    input  wire  [$clog2(DEPTH+1)-1:0]            count,
    input  wire  [mtf_pkg::VALUE_W-1:0]           nb_value,
    input  wire  [mtf_pkg::VALUE_W-1:0]           nb_smax,
    output logic [mtf_pkg::VALUE_W-1:0]           value,
    output logic [mtf_pkg::VALUE_W-1:0]           smax
);
    import mtf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] smax_reg;
    logic [VALUE_W-1:0] smax_next;
    logic               load_here;

    assign load_here = ctrl.push && (count == IDX);

    // Load at the tail, raise the suffix maximum on push, shift toward the head on pop
    always_comb
    begin
        value_next = value_reg;
        smax_next  = smax_reg;
        priority if (load_here)
        begin
            value_next = ctrl.push_value;
            smax_next  = ctrl.push_value;
        end
        else if (ctrl.push)
        begin
            smax_next = max_val(smax_reg, ctrl.push_value);
        end
        else if (ctrl.pop)
        begin
            value_next = nb_value;
            smax_next  = nb_smax;
        end
    end

    // Entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        smax_reg  <= smax_next;
    end

    assign value = value_reg;
    assign smax  = smax_reg;

endmodule

`default_nettype wire

// ===== verif/mtf_checker.sv =====
// Checker for the max-tracking queue: predicts each result and compares it with the output.
module mtf_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [30:0] value
    input  wire         s_axis_tuser,   // [0] kind
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [79:0] m_axis_tdata,   // [31:0] popped_value, [63:32] current_max,
                                        // [72:64] occupancy
    input  wire  [1:0]  m_axis_tuser,   // [1:0] status
    output int          errors,
    output int          pending
);
    import mtf_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [WORD_W-1:0] popped_value;
        logic [WORD_W-1:0] current_max;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    // Mirror of the queue contents, oldest first, and its tracked maximum
    logic [VALUE_W-1:0] held_values[$];
    int                 tracked_max = -1;
    queue_result_t      awaited_results[$];
    queue_result_t      want;
    queue_result_t      got;

    // Apply one operation to the mirror and return the result it must produce
    function automatic queue_result_t apply_queue_op(input logic kind,
                                                      input logic [VALUE_W-1:0] value);
        queue_result_t r;
        int            popped;
        popped = -1;
        r.status = STAT_OK;
        if (kind == KIND_PUSH)
        begin
            if (held_values.size() >= mtf_pkg::DEPTH_DEFAULT)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                held_values.push_back(value);
                if (int'(value) > tracked_max)
                    tracked_max = int'(value);
            end
        end
        else
        begin
            if (held_values.size() == 0)
            begin
                r.status = STAT_EMPTY;
                tracked_max = -1;
            end
            else
            begin
                popped = int'(held_values.pop_front());
                // Rescan the remaining entries when the maximum leaves
                if (tracked_max <= popped)
                begin
                    tracked_max = -1;
                    foreach (held_values[i])
                        if (int'(held_values[i]) > tracked_max)
                            tracked_max = int'(held_values[i]);
                end
            end
        end
        r.popped_value = popped;
        r.current_max  = tracked_max;
        r.occupancy    = OCC_W'(held_values.size());
        return r;
    endfunction

    // Count a failure and report it while the report budget lasts
    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endtask

    // Compare each result transfer, then predict each input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.popped_value = m_axis_tdata[31:0];
                got.current_max  = m_axis_tdata[63:32];
                got.occupancy    = m_axis_tdata[72:64];
                got.status       = m_axis_tuser;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none actual %h/%h",
                                 $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.popped_value !== want.popped_value)
                        report_mismatch("popped_value", want.popped_value, got.popped_value);
                    if (got.current_max !== want.current_max)
                        report_mismatch("current_max", want.current_max, got.current_max);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(want.occupancy),
                                        32'(got.occupancy));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(apply_queue_op(s_axis_tuser,
                                                         s_axis_tdata[VALUE_W-1:0]));
            pending = awaited_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the max-tracking queue: clock, reset, stimulus and verdict.
module tb;
    import mtf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_STALL   = 400;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = KIND_PUSH;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int errors;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;
    int cycle_count = 0;
    bit stall_request = 1'b0;

    max_tracking_fifo u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mtf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    always #4 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drive the receiver ready, with one long hold-off on request
    always @(posedge clk)
    begin : receiver
        static int  stall_left = 0;
        static bit  stall_taken = 1'b0;
        if (stall_request && !stall_taken)
        begin
            stall_taken = 1'b1;
            stall_left  = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one item and hold it until the transfer completes
    task automatic send_item(input logic kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Pick a value: mostly small ones so duplicates and rescans of equal maxima occur
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0, 1:    return VALUE_W'($urandom_range(7));
            2:       return VALUE_W'($urandom);
            3:       return 31'h7fff_ffff;
            4:       return '0;
            default: return VALUE_W'($urandom_range(1000));
        endcase
    endfunction

    // Send a run of random items with the given share of pushes
    task automatic send_random(input int count, input int push_pct);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP, pick_value());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, extremes, max leaving, equal maxima, ignored pop value
        send_idle = 23;
        recv_idle = 55;
        send_item(KIND_POP,  31'h7fff_ffff);
        send_item(KIND_PUSH, 31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_PUSH, 31'h0);
        send_item(KIND_PUSH, 31'h7fff_ffff);
        send_item(KIND_PUSH, 31'd5);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h2aaa_aaaa);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_PUSH, 31'd3);
        send_item(KIND_PUSH, 31'd3);
        send_item(KIND_PUSH, 31'd1);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_PUSH, 31'h2aaa_aaaa);
        send_item(KIND_PUSH, 31'h5555_5555);
        send_item(KIND_PUSH, 31'h1);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h0);
        send_item(KIND_POP,  31'h5555_5555);

        // Balanced mix that keeps hitting the empty queue
        send_random(40, 50);

        // Fill past full under a long receiver hold-off
        send_idle = 55;
        recv_idle = 23;
        stall_request <= 1'b1;
        send_random(262, 100);
        send_random(10, 60);

        // Drain part of the way with no idling
        send_idle = 0;
        recv_idle = 0;
        send_random(65, 15);
        s_axis_tvalid <= 1'b0;

        // Wait for every result, then let the pipeline settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
